FILE: rtl/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg - shared types and constants for polyline length and integrals
// Point word layout, result field widths and the back end sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plc_pkg;

  localparam int FIELD_W     = 32;
  localparam int IN_TDATA_W  = 7 * FIELD_W;
  localparam int SEG_W       = 33;
  localparam int LEN_W       = 48;
  localparam int SUM_W       = 64;
  localparam int SLOPE_W     = 48;
  localparam int OUT_FIELD_W = SEG_W + LEN_W + 2 * SUM_W + SLOPE_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // shared multiplier operand width covers a 33-bit difference and the length
  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DOT_W  = PROD_W + 2;
  localparam int NUM_OPS = 6;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  localparam logic [63:0] SEG_MAX64   = 64'h0000_0001_FFFF_FFFF;
  localparam logic [63:0] SLOPE_POS64 = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] SLOPE_NEG64 = 64'h0000_8000_0000_0000;

  typedef struct packed {
    logic                          first;
    logic [2:0][FIELD_W-1:0]       pos;
    logic [FIELD_W-1:0]            sample;
    logic [2:0][FIELD_W-1:0]       vec;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_SQRT,
    ST_SMUL,
    ST_DIV,
    ST_DONE
  } back_state_t;

  function automatic logic [SUM_W-1:0] sat_add64(input logic [SUM_W-1:0] a,
                                                  input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return s[SUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/plc_front.sv
// ----------------------------------------------------------------------------
// plc_front - input side
// Takes point words, marks the ones that start a line and pushes them on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plc_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [plc_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic                        in_tuser,
  input  wire logic                        q_full,
  output logic                             q_push,
  output plc_pkg::item_t                   q_item
);
  import plc_pkg::*;

  logic have_prev_r, have_prev_nxt;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  // no earlier point means this one starts a line too
  always_comb begin
    q_item.first  = in_tuser || !have_prev_r;
    q_item.pos[0] = in_tdata[0*FIELD_W +: FIELD_W];
    q_item.pos[1] = in_tdata[1*FIELD_W +: FIELD_W];
    q_item.pos[2] = in_tdata[2*FIELD_W +: FIELD_W];
    q_item.sample = in_tdata[3*FIELD_W +: FIELD_W];
    q_item.vec[0] = in_tdata[4*FIELD_W +: FIELD_W];
    q_item.vec[1] = in_tdata[5*FIELD_W +: FIELD_W];
    q_item.vec[2] = in_tdata[6*FIELD_W +: FIELD_W];
  end

  assign have_prev_nxt = have_prev_r || q_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
    end else begin
      have_prev_r <= have_prev_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/plc_queue.sv
// ----------------------------------------------------------------------------
// plc_queue - point queue
// Short FIFO between the input side and the arithmetic sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plc_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  plc_pkg::item_t      push_item,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output plc_pkg::item_t      head_item
);
  import plc_pkg::*;

  item_t            slot_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [Q_AW:0]    cnt_r, cnt_nxt;

  assign full       = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = slot_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop  ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/plc_back.sv
// ----------------------------------------------------------------------------
// plc_back - arithmetic sequencer
// Shared multiplier, bitwise square root and restoring divider, then the
// saturating sums and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plc_back #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_valid,
  input  plc_pkg::item_t                      q_item,
  output logic                                q_pop,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [plc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tuser
);
  import plc_pkg::*;

  localparam int D_W   = COORD_WIDTH + 1;
  localparam int SQ_W  = 2 * D_W + 2;
  localparam int RT_W  = D_W + 1;
  localparam int DIV_W = D_W + FRAC_BITS;
  localparam int CNT_W = $clog2(DIV_W + 1);
  localparam int SH    = FRAC_BITS + 1;

  back_state_t state_r, state_nxt;

  logic signed [D_W-1:0] cur_p [3];
  logic signed [D_W-1:0] cur_w [3];
  logic signed [D_W-1:0] cur_v;

  logic signed [D_W-1:0] prev_p_r [3];
  logic signed [D_W-1:0] prev_w_r [3];
  logic signed [D_W-1:0] prev_v_r;

  logic signed [D_W-1:0] d_r  [3];
  logic signed [D_W-1:0] ws_r [3];
  logic signed [D_W-1:0] vs_r, vd_r;
  logic                  first_r;

  logic [2:0]               op_r;
  logic [1:0]               lane;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic [SQ_W-1:0]          sq_r;
  logic signed [DOT_W-1:0]  dot_r;

  logic [SQ_W-1:0]   rad_r;
  logic [RT_W:0]     rem_r, rem_nxt;
  logic [RT_W-1:0]   root_r, root_nxt;
  logic [RT_W+2:0]   s_cat, s_sub, s_trial;
  logic              s_ge;
  logic [63:0]       root64;
  logic [SEG_W-1:0]  seg_sat, seg_r;

  logic [DIV_W-1:0]  dvd_r, quo_r, quo_nxt;
  logic [SEG_W-1:0]  drem_r, drem_nxt;
  logic [SEG_W:0]    d_cat, d_trial;
  logic              d_ge;
  logic [D_W-1:0]    vd_mag;
  logic [CNT_W-1:0]  cnt_r;

  logic [LEN_W-1:0]  len_sum_r, len_new;
  logic [SUM_W-1:0]  ssum_r, vsum_r, ssum_new, vsum_new;
  logic [LEN_W:0]    len_add;
  logic signed [PROD_W-1:0] s_shift;
  logic signed [DOT_W-1:0]  v_shift;
  logic [63:0]       q64, qsat, qneg;
  logic [SLOPE_W-1:0] slope_new;
  logic [SEG_W-1:0]  seg_new;
  logic              inv_new;

  logic out_valid_r, out_valid_nxt, out_free, load_out;

  // ---- operand unpacking (low COORD_WIDTH bits, two's complement)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cur_p[i] = D_W'($signed(q_item.pos[i][COORD_WIDTH-1:0]));
      cur_w[i] = D_W'($signed(q_item.vec[i][COORD_WIDTH-1:0]));
    end
    cur_v = D_W'($signed(q_item.sample[COORD_WIDTH-1:0]));
  end

  // ---- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (q_valid) state_nxt = q_item.first ? ST_DONE : ST_MUL;
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC:  if (op_r == 3'(NUM_OPS - 1)) state_nxt = ST_SQRT;
               else state_nxt = ST_MUL;
      ST_SQRT: if (cnt_r == CNT_W'(RT_W - 1)) state_nxt = ST_SMUL;
      ST_SMUL: state_nxt = (seg_r == '0) ? ST_DONE : ST_DIV;
      ST_DIV:  if (cnt_r == CNT_W'(DIV_W - 1)) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---- control strobes
  assign out_free = !out_valid_r || out_tready;
  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: q_pop    = q_valid;
      ST_DONE: load_out = out_free;
      default: ;
    endcase
  end

  // ---- shared multiplier: squares, then dot terms, then length * sample sum
  assign lane = (op_r < 3'd3) ? op_r[1:0] : 2'(op_r - 3'd3);
  always_comb begin
    if (state_r == ST_SMUL) begin
      mul_a = $signed({1'b0, seg_r});
      mul_b = MUL_W'(vs_r);
    end else begin
      mul_a = MUL_W'(d_r[lane]);
      mul_b = (op_r < 3'd3) ? MUL_W'(d_r[lane]) : MUL_W'(ws_r[lane]);
    end
  end

  // ---- square root step, two radicand bits per cycle
  always_comb begin
    s_cat    = {rem_r, rad_r[SQ_W-1 -: 2]};
    s_sub    = (RT_W+3)'({root_r, 2'b01});
    s_trial  = s_cat - s_sub;
    s_ge     = (s_cat >= s_sub);
    rem_nxt  = s_ge ? s_trial[RT_W:0] : s_cat[RT_W:0];
    root_nxt = {root_r[RT_W-2:0], s_ge};
    root64   = 64'(root_nxt);
    seg_sat  = (root64 > SEG_MAX64) ? '1 : root64[SEG_W-1:0];
  end

  // ---- divider step, one quotient bit per cycle
  always_comb begin
    d_cat    = {drem_r, dvd_r[DIV_W-1]};
    d_trial  = d_cat - {1'b0, seg_r};
    d_ge     = (d_cat >= {1'b0, seg_r});
    drem_nxt = d_ge ? d_trial[SEG_W-1:0] : d_cat[SEG_W-1:0];
    quo_nxt  = {quo_r[DIV_W-2:0], d_ge};
    vd_mag   = vd_r[D_W-1] ? D_W'(-vd_r) : vd_r;
  end

  // ---- result assembly
  always_comb begin
    len_add  = {1'b0, len_sum_r} + (LEN_W+1)'(seg_r);
    s_shift  = prod_r >>> SH;
    v_shift  = dot_r >>> SH;
    q64      = 64'(quo_r);
    if (vd_r[D_W-1]) begin
      qsat = (q64 > SLOPE_NEG64) ? SLOPE_NEG64 : q64;
    end else begin
      qsat = (q64 > SLOPE_POS64) ? SLOPE_POS64 : q64;
    end
    qneg = -qsat;
    if (first_r) begin
      seg_new   = '0;
      len_new   = '0;
      ssum_new  = '0;
      vsum_new  = '0;
      slope_new = '0;
      inv_new   = 1'b1;
    end else begin
      seg_new  = seg_r;
      len_new  = len_add[LEN_W] ? '1 : len_add[LEN_W-1:0];
      ssum_new = sat_add64(ssum_r, s_shift[SUM_W-1:0]);
      vsum_new = sat_add64(vsum_r, v_shift[SUM_W-1:0]);
      inv_new  = (seg_r == '0);
      if (seg_r == '0) begin
        slope_new = '0;
      end else begin
        slope_new = vd_r[D_W-1] ? qneg[SLOPE_W-1:0] : qsat[SLOPE_W-1:0];
      end
    end
  end

  assign out_valid_nxt = load_out || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      first_r <= q_item.first;
      for (int i = 0; i < 3; i++) begin
        d_r[i]      <= cur_p[i] - prev_p_r[i];
        ws_r[i]     <= cur_w[i] + prev_w_r[i];
        prev_p_r[i] <= cur_p[i];
        prev_w_r[i] <= cur_w[i];
      end
      vs_r     <= cur_v + prev_v_r;
      vd_r     <= cur_v - prev_v_r;
      prev_v_r <= cur_v;
      op_r     <= '0;
      sq_r     <= '0;
      dot_r    <= '0;
    end
    if (state_r == ST_MUL || state_r == ST_SMUL) begin
      prod_r <= mul_a * mul_b;
    end
    if (state_r == ST_ACC) begin
      op_r <= op_r + 3'd1;
      if (op_r < 3'd3) begin
        sq_r <= sq_r + prod_r[SQ_W-1:0];
      end else begin
        dot_r <= dot_r + DOT_W'(prod_r);
      end
      if (op_r == 3'(NUM_OPS - 1)) begin
        rad_r  <= sq_r;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
      end
    end
    if (state_r == ST_SQRT) begin
      rad_r  <= {rad_r[SQ_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      cnt_r  <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(RT_W - 1)) begin
        seg_r <= seg_sat;
      end
    end
    if (state_r == ST_SMUL) begin
      dvd_r  <= {vd_mag, {FRAC_BITS{1'b0}}};
      drem_r <= '0;
      quo_r  <= '0;
      cnt_r  <= '0;
    end
    if (state_r == ST_DIV) begin
      dvd_r  <= {dvd_r[DIV_W-2:0], 1'b0};
      drem_r <= drem_nxt;
      quo_r  <= quo_nxt;
      cnt_r  <= cnt_r + 1'b1;
    end
    if (load_out) begin
      len_sum_r <= len_new;
      ssum_r    <= ssum_new;
      vsum_r    <= vsum_new;
      out_tdata <= {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}}, slope_new, vsum_new,
                    ssum_new, len_new, seg_new};
      out_tuser <= inv_new;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

FILE: rtl/polyline_length_and_integrals.sv
// ----------------------------------------------------------------------------
// polyline_length_and_integrals - arc length and line integrals of a polyline
// Per point: segment length, running arc length, trapezoidal scalar integral,
// vector line integral and scalar slope, with saturating accumulators.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                         | tuser
//  in_     | in  | pos_x,pos_y,pos_z,sample_value,vec_x,vec_y,   | first_point
//          |     | vec_z (32 b each, low bits first)             |
//  out_    | out | segment_length,arc_length,scalar_integral,    | slope_invalid
//          |     | vector_integral,slope, zero pad to 264 b      |
//
//  Per point: a line start goes straight to its result word; otherwise
//  the multiply-accumulate steps, (COORD_WIDTH+2) square root steps, a
//  slope multiply and (COORD_WIDTH+1+FRAC_BITS) divide steps run in turn
//  (no divide for a zero-length segment); square root and divider dominate.
//  A two-word queue takes input while the sequencer works; the output
//  register holds a word under backpressure. rst_n clears all control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module polyline_length_and_integrals #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // pos_x, pos_y, pos_z, sample_value, vec_x, vec_y, vec_z
  input  wire logic [plc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // first_point
  input  wire logic                            in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // segment_length, arc_length, scalar_integral, vector_integral, slope, pad
  output logic [plc_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // slope_invalid
  output logic                                 out_tuser
);
  import plc_pkg::*;

  item_t push_item, head_item;
  logic  push, full, pop, head_valid;

  plc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (full),
    .q_push    (push),
    .q_item    (push_item)
  );

  plc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  plc_back #(
    .FRAC_BITS   (FRAC_BITS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (head_valid),
    .q_item     (head_item),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

FILE: rtl/plc_checker.sv
// ----------------------------------------------------------------------------
// plc_checker - port level checks
// Output handshake and result consistency seen at the top level ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plc_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [plc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                           out_tuser
);

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped under stall");

  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed under stall");

  // an invalid slope is reported as zero
  a_slope_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[256:209] == 48'd0)
    else $error("slope not zero while flagged invalid");

  // zero segment length never carries a valid slope
  a_zero_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[32:0] == 33'd0 |-> out_tuser)
    else $error("slope valid on zero-length segment");

endmodule

bind polyline_length_and_integrals plc_checker u_plc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

FILE: bench/polyline_length_and_integrals_test.sv
// ----------------------------------------------------------------------------
// polyline_length_and_integrals_test - self-checking bench for the polyline unit
// Drives point words with random gaps, predicts segment length, arc length,
// both integrals and the slope per point, and checks every result word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module polyline_length_and_integrals_test;
  import plc_pkg::*;

  localparam int FRAC = 16;
  localparam logic [32:0]  SEG_SAT = {33{1'b1}};
  localparam logic [47:0]  LEN_SAT = {48{1'b1}};
  localparam logic signed [63:0] I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] I64_MIN = 64'sh8000_0000_0000_0000;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic [32:0]        seg;
    logic [47:0]        arc;
    logic signed [63:0] sint;
    logic signed [63:0] vint;
    logic [47:0]        slope;
    logic               inval;
  } point_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;

  polyline_length_and_integrals u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // predictor state
  logic signed [31:0] last_pos [3];
  logic signed [31:0] last_val;
  logic signed [31:0] last_vec [3];
  logic [47:0]        len_acc;
  logic signed [63:0] sint_acc;
  logic signed [63:0] vint_acc;
  logic               seen_point;

  point_result_t expected_results[$];
  int  fail_count = 0;
  int  cycle_count = 0;
  bit  sender_gaps = 1'b1;
  bit  receiver_gaps = 1'b1;
  int  hold_cycles = 0;
  // flipped by a test to ask the receiver for one long hold-off
  bit  hold_toggle = 1'b0;
  bit  hold_toggle_seen = 1'b0;

  function automatic logic signed [63:0] sat_sum(logic signed [63:0] a,
                                                  logic signed [129:0] b);
    logic signed [130:0] s;
    s = a + b;
    if (s > I64_MAX) return I64_MAX;
    if (s < I64_MIN) return I64_MIN;
    return s[63:0];
  endfunction

  function automatic logic [34:0] floor_sqrt(logic [127:0] sq);
    logic [34:0]  r;
    logic [34:0]  t;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      t = r | (35'd1 << b);
      if ({93'd0, t} * {93'd0, t} <= sq) r = t;
    end
    return r;
  endfunction

  function automatic point_result_t predict_point(logic first, logic signed [31:0] p[3],
                                                  logic signed [31:0] v,
                                                  logic signed [31:0] w[3]);
    point_result_t r;
    logic signed [33:0]  d;
    logic [127:0]        sq;
    logic signed [129:0] dot;
    logic signed [129:0] prod;
    logic [34:0]         root;
    logic signed [33:0]  diff;
    logic [63:0]         q;
    logic [49:0]         len_next;
    r.seg = '0; r.slope = '0; r.inval = 1'b1;
    if (first || !seen_point) begin
      len_acc = '0; sint_acc = '0; vint_acc = '0;
    end else begin
      sq = '0; dot = '0;
      for (int i = 0; i < 3; i++) begin
        d = $signed({p[i][31], p[i]}) - $signed({last_pos[i][31], last_pos[i]});
        sq += 128'(d * d);
        dot += 130'(d) * 130'($signed({w[i][31], w[i]}) + $signed({last_vec[i][31], last_vec[i]}));
      end
      root = floor_sqrt(sq);
      r.seg = (root > {2'b0, SEG_SAT}) ? SEG_SAT : root[32:0];
      len_next = {2'b0, len_acc} + {17'b0, r.seg};
      len_acc = (len_next > {2'b0, LEN_SAT}) ? LEN_SAT : len_next[47:0];
      prod = $signed({97'b0, r.seg}) * 130'($signed({v[31], v}) + $signed({last_val[31], last_val}));
      sint_acc = sat_sum(sint_acc, prod >>> (FRAC + 1));
      vint_acc = sat_sum(vint_acc, dot >>> (FRAC + 1));
      if (r.seg != 0) begin
        diff = $signed({v[31], v}) - $signed({last_val[31], last_val});
        q = ({30'b0, (diff < 0) ? -diff : diff} << FRAC) / {31'b0, r.seg};
        r.inval = 1'b0;
        if (diff < 0) begin
          if (q > SLOPE_NEG64) q = SLOPE_NEG64;
          r.slope = 48'(-q);
        end else begin
          if (q > SLOPE_POS64) q = SLOPE_POS64;
          r.slope = q[47:0];
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      last_pos[i] = p[i];
      last_vec[i] = w[i];
    end
    last_val = v;
    seen_point = 1'b1;
    r.arc = len_acc; r.sint = sint_acc; r.vint = vint_acc;
    return r;
  endfunction

  // valid stays high after a word is taken; the next call replaces the data
  task automatic send_point(logic first, logic signed [31:0] p[3], logic signed [31:0] v,
                            logic signed [31:0] w[3]);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= first;
    in_tdata  <= {w[2], w[1], w[0], v, p[2], p[1], p[0]};
    expected_results.insert(expected_results.size(), predict_point(first, p, v, w));
    do @(posedge clk); while (!in_tready);
  endtask

  // mostly small values so that segments stay short, sometimes full range
  function automatic logic signed [31:0] rand_field(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
      default: return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endcase
  endfunction

  task automatic send_random(logic first, int mode);
    logic signed [31:0] p[3];
    logic signed [31:0] w[3];
    logic signed [31:0] v;
    for (int i = 0; i < 3; i++) begin
      p[i] = rand_field(mode);
      w[i] = rand_field(mode);
    end
    v = rand_field(mode);
    send_point(first, p, v, w);
  endtask

  task automatic test_directed();
    logic signed [31:0] p[3];
    logic signed [31:0] w[3];
    p = '{0, 0, 0}; w = '{0, 0, 0};
    send_point(1'b0, p, 0, w);                 // start without flag
    p = '{32'sh0003_0000, 32'sh0004_0000, 0};
    w = '{32'sh0001_0000, 0, 0};
    send_point(1'b0, p, 32'sh0002_0000, w);    // 3-4-5 segment
    send_point(1'b0, p, 32'sh0005_0000, w);    // zero-length segment
    p = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
    w = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
    send_point(1'b1, p, 32'sh7FFF_FFFF, w);
    p = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
    w = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
    send_point(1'b0, p, 32'sh8000_0000, w);    // longest segment, length not saturated
    p = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
    send_point(1'b0, p, 32'sh7FFF_FFFF, w);
    for (int k = 0; k < 8; k++) begin           // drive sums toward saturation
      p[0] = (k % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      w = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
      send_point(1'b0, p, 32'sh7FFF_FFFF, w);
    end
    p = '{0, 0, 0};
    send_point(1'b1, p, 32'sh8000_0000, w);
    p = '{1, 0, 0};
    send_point(1'b0, p, 32'sh7FFF_FFFF, w);    // tiny segment, slope clips high
    p = '{0, 0, 0};
    send_point(1'b0, p, 32'sh8000_0000, w);    // slope clips low
    send_point(1'b1, p, 0, w);
  endtask

  task automatic test_random_lines(int n);
    int left;
    left = n;
    while (left > 0) begin
      int run_len;
      int mode;
      run_len = $urandom_range(1, 20);
      mode = ($urandom_range(0, 9) == 0) ? 0 : (($urandom_range(0, 19) == 0) ? 2 : 1);
      for (int k = 0; k < run_len && left > 0; k++) begin
        send_random(k == 0 && $urandom_range(0, 3) != 0, mode);
        left--;
      end
    end
  endtask

  task automatic test_backpressure();
    hold_toggle = ~hold_toggle;
    repeat (8) send_random(1'b0, 1);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_toggle != hold_toggle_seen) begin
      hold_toggle_seen <= hold_toggle;
      hold_cycles <= LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else if (receiver_gaps && $urandom_range(0, 15) == 0) begin
      out_tready <= 1'b0;
      hold_cycles <= $urandom_range(1, 12) - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    point_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        if (out_tdata[32:0] !== e.seg) begin
          $error("segment_length exp %h got %h", e.seg, out_tdata[32:0]); fail_count++;
        end
        if (out_tdata[80:33] !== e.arc) begin
          $error("arc_length exp %h got %h", e.arc, out_tdata[80:33]); fail_count++;
        end
        if (out_tdata[144:81] !== e.sint) begin
          $error("scalar_integral exp %h got %h", e.sint, out_tdata[144:81]); fail_count++;
        end
        if (out_tdata[208:145] !== e.vint) begin
          $error("vector_integral exp %h got %h", e.vint, out_tdata[208:145]); fail_count++;
        end
        if (out_tdata[256:209] !== e.slope) begin
          $error("slope exp %h got %h", e.slope, out_tdata[256:209]); fail_count++;
        end
        if (out_tuser !== e.inval) begin
          $error("slope_invalid exp %b got %b", e.inval, out_tuser); fail_count++;
        end
      end
    end
  end

  initial begin
    last_pos = '{0, 0, 0}; last_vec = '{0, 0, 0}; last_val = 0;
    len_acc = '0; sint_acc = '0; vint_acc = '0; seen_point = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_lines(1300);
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    test_random_lines(200);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
